// ----- sv/lpbs_pkg.sv -----
// Shared types and constants for the LED PWM bit serializer.
`timescale 1ns / 1ps

package lpbs_pkg;

  // Pixel buffer geometry
  localparam int unsigned BufBytes = 192;
  localparam int unsigned BufAw    = $clog2(BufBytes);

  // Register reset values
  localparam logic [7:0] HighCmpRst    = 8'd60;
  localparam logic [7:0] LowCmpRst     = 8'd11;
  localparam logic [7:0] LatchTicksRst = 8'd40;

  // MSB of the shift byte is the bit on the wire
  localparam logic [7:0] MsbMask = 8'h80;

  // Item opcodes
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_HIGH_CMP    = 2'd0,
    REG_LOW_CMP     = 2'd1,
    REG_LATCH_TICKS = 2'd2
  } cfg_reg_e;

  // Current register set
  typedef struct packed {
    logic [7:0] high_cmp;
    logic [7:0] low_cmp;
    logic [7:0] latch_ticks;
  } cfg_t;

  // Pixel memory access request
  typedef struct packed {
    logic             we;
    logic [BufAw-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [BufAw-1:0] raddr;
  } mem_req_t;

endpackage

// ----- sv/lpbs_cfg_regs.sv -----
// Configuration register file for the LED PWM bit serializer.
`timescale 1ns / 1ps

module lpbs_cfg_regs import lpbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HIGH_CMP:    cfg_d.high_cmp    = cfg_data_i;
        REG_LOW_CMP:     cfg_d.low_cmp     = cfg_data_i;
        REG_LATCH_TICKS: cfg_d.latch_ticks = cfg_data_i;
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_cmp    <= HighCmpRst;
      cfg_q.low_cmp     <= LowCmpRst;
      cfg_q.latch_ticks <= LatchTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/lpbs_pixel_mem.sv -----
// Pixel byte buffer: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps

module lpbs_pixel_mem import lpbs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output logic [7:0] rdata_o
);

  logic [7:0]          mem_q [BufBytes];
  logic [BufBytes-1:0] vld_q;
  logic [7:0]          rd_q;
  logic                rd_vld_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  // Valid bits: an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : 8'h00;

endmodule

// ----- sv/led_pwm_bit_serializer.sv -----
// Top level: LED colour bytes serialized into one PWM compare value per tick.
// A tick's result is captured in the output register when the tick is accepted.
// Throughput: one item per cycle while the result side does not stall; buffer writes give no result.
// The next byte is read from the pixel memory on the eighth bit and forwarded from
// its read register, so ticks may follow back to back.
// Reset: registers to defaults, buffer reads as zero until written, shift byte zero.
`timescale 1ns / 1ps

module led_pwm_bit_serializer import lpbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input items
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       opcode_i,
  input  logic [7:0] buf_addr_i,
  input  logic [7:0] buf_data_i,
  // Result items
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] duty_compare_o,
  output logic       latch_active_o,
  // Configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t       cfg;
  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  logic             acc;
  logic             tick;
  logic [BufAw-1:0] ptr_q, ptr_d, ptr_nxt;
  logic [2:0]       bit_q, bit_d;
  logic [7:0]       latch_q, latch_d;
  logic [7:0]       shift_q, shift_d, shift_eff;
  logic             pend_q, pend_d;
  logic             out_vld_q, out_vld_d;
  logic [7:0]       duty_q, duty_d;
  logic             lat_q, lat_d;

  assign cfg_ready_o = 1'b1;

  lpbs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lpbs_pixel_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register drains in the same cycle it is refilled
  assign in_stall_o = out_vld_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign tick       = acc && (opcode_e'(opcode_i) == OP_TICK);

  // Byte just read from memory is forwarded until captured
  assign shift_eff = pend_q ? mem_rdata : shift_q;
  assign ptr_nxt   = (ptr_q == BufAw'(BufBytes - 1)) ? '0 : ptr_q + 1'b1;

  // Buffer writes; out-of-range addresses dropped
  always_comb begin
    mem_req       = '0;
    mem_req.we    = acc && (opcode_e'(opcode_i) == OP_WRITE)
                    && ({1'b0, buf_addr_i} < 9'(BufBytes));
    mem_req.waddr = BufAw'(buf_addr_i);
    mem_req.wdata = buf_data_i;
    mem_req.raddr = ptr_nxt;
    mem_req.re    = 1'b0;
    // Serializer step
    ptr_d     = ptr_q;
    bit_d     = bit_q;
    latch_d   = latch_q;
    shift_d   = shift_eff;
    pend_d    = 1'b0;
    out_vld_d = out_vld_q && out_stall_i;
    duty_d    = duty_q;
    lat_d     = lat_q;
    if (tick) begin
      out_vld_d = 1'b1;
      if (latch_q != 8'd0) begin
        latch_d = latch_q - 1'b1;
        duty_d  = 8'h00;
        lat_d   = 1'b1;
      end else begin
        duty_d  = ((shift_eff & MsbMask) != 8'h00) ? cfg.high_cmp : cfg.low_cmp;
        lat_d   = 1'b0;
        shift_d = {shift_eff[6:0], 1'b0};
        if (bit_q == 3'd7) begin
          bit_d      = 3'd0;
          ptr_d      = ptr_nxt;
          mem_req.re = 1'b1;
          pend_d     = 1'b1;
          if (ptr_nxt == '0) begin
            latch_d = cfg.latch_ticks;
          end
        end else begin
          bit_d = bit_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      bit_q     <= '0;
      latch_q   <= '0;
      shift_q   <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      ptr_q     <= ptr_d;
      bit_q     <= bit_d;
      latch_q   <= latch_d;
      shift_q   <= shift_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    duty_q <= duty_d;
    lat_q  <= lat_d;
  end

  assign out_valid_o    = out_vld_q;
  assign duty_compare_o = duty_q;
  assign latch_active_o = lat_q;

endmodule

// ----- tb/lpbs_duty_check.sv -----
// Checker for the LED PWM bit serializer: watches all channels, predicts and compares.
`timescale 1ns / 1ps

module lpbs_duty_check import lpbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Request channel as seen at the block
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       opcode_i,
  input  logic [7:0] buf_addr_i,
  input  logic [7:0] buf_data_i,
  // Result channel
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] duty_compare_i,
  input  logic       latch_active_i,
  // Register writes
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  // Status back to the top
  output int         errors_o,
  output int         pending_o
);

  // One expected PWM period
  typedef struct packed {
    logic [7:0] duty;
    logic       latch;
  } pulse_t;

  pulse_t      pulse_q[$];

  // Mirror of the serializer state
  cfg_t        regs;
  logic [7:0]  pix_mem [BufBytes];
  int unsigned byte_ptr;
  logic [2:0]  bit_idx;
  logic [7:0]  gap_left;
  logic [7:0]  shreg;

  task automatic report_mismatch(input string what);
    $display("[%0t] ERROR: %s", $time, what);
    errors_o++;
  endtask

  // Advance the mirror by one timer period and return the compare value it gives
  function automatic pulse_t serialize_tick();
    pulse_t p;
    if (gap_left != 8'd0) begin
      gap_left = gap_left - 8'd1;
      p.duty   = 8'd0;
      p.latch  = 1'b1;
      return p;
    end
    p.duty  = ((shreg & MsbMask) != 8'd0) ? regs.high_cmp : regs.low_cmp;
    p.latch = 1'b0;
    shreg   = shreg << 1;
    if (bit_idx == 3'd7) begin
      bit_idx  = 3'd0;
      byte_ptr = byte_ptr + 1;
      // end of frame: wrap and open the latch gap
      if (byte_ptr >= BufBytes) begin
        byte_ptr = 0;
        gap_left = regs.latch_ticks;
      end
      shreg = pix_mem[byte_ptr];
    end else begin
      bit_idx = bit_idx + 3'd1;
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pulse_t got;
    pulse_t want;
    if (!rst_ni) begin
      regs.high_cmp    = HighCmpRst;
      regs.low_cmp     = LowCmpRst;
      regs.latch_ticks = LatchTicksRst;
      for (int i = 0; i < BufBytes; i++) pix_mem[i] = 8'd0;
      byte_ptr  = 0;
      bit_idx   = 3'd0;
      gap_left  = 8'd0;
      shreg     = 8'd0;
      pulse_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_i)
          REG_HIGH_CMP:    regs.high_cmp = cfg_data_i;
          REG_LOW_CMP:     regs.low_cmp = cfg_data_i;
          REG_LATCH_TICKS: regs.latch_ticks = cfg_data_i;
          default: ;
        endcase
      end

      // results first: an expectation is never produced and consumed on one edge
      if (out_valid_i && !out_stall_i) begin
        got.duty  = duty_compare_i;
        got.latch = latch_active_i;
        if (pulse_q.size() == 0) begin
          report_mismatch($sformatf("result duty=%0d latch=%0b with nothing expected",
                                    got.duty, got.latch));
        end else begin
          want = pulse_q.pop_front();
          if (got.duty !== want.duty)
            report_mismatch($sformatf("duty_compare: got %0d, expected %0d",
                                      got.duty, want.duty));
          if (got.latch !== want.latch)
            report_mismatch($sformatf("latch_active: got %0b, expected %0b",
                                      got.latch, want.latch));
        end
      end

      // accepted requests
      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_WRITE) begin
          // writes past the buffer are dropped
          if (buf_addr_i < BufBytes) pix_mem[buf_addr_i] = buf_data_i;
        end else begin
          pulse_q.push_back(serialize_tick());
        end
      end

      pending_o = pulse_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the LED PWM bit serializer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import lpbs_pkg::*;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic       opcode_i       = 1'b0;
  logic [7:0] buf_addr_i     = 8'd0;
  logic [7:0] buf_data_i     = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [7:0] duty_compare_o;
  logic       latch_active_o;
  logic       cfg_valid_i    = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_idx_i      = 2'd0;
  logic [7:0] cfg_data_i     = 8'd0;

  int         errors;
  int         pending;
  bit         in_steady;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  led_pwm_bit_serializer uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .opcode_i, .buf_addr_i, .buf_data_i,
    .out_valid_o, .out_stall_i, .duty_compare_o, .latch_active_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_idx_i, .cfg_data_i
  );

  lpbs_duty_check u_duty_check (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .buf_addr_i, .buf_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .duty_compare_i(duty_compare_o),
    .latch_active_i(latch_active_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // Present one request after a random gap and hold it until taken
  task automatic send_req(input opcode_e op, input logic [7:0] addr, input logic [7:0] data);
    int   gap;
    logic stalled;
    gap = in_steady ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    buf_addr_i <= addr;
    buf_data_i <= data;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  // Stop sending and let every outstanding result drain
  task automatic settle();
    in_valid_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (pending == 0) break;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] val);
    logic rdy;
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic program_regs(input logic [7:0] hi, input logic [7:0] lo,
                              input logic [7:0] gap);
    settle();
    write_reg(REG_HIGH_CMP, hi);
    write_reg(REG_LOW_CMP, lo);
    write_reg(REG_LATCH_TICKS, gap);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: random stall before each result, with stall-free stretches
  initial begin : result_sink
    int   hold;
    int   served;
    bit   out_steady;
    logic seen;
    served = 0;
    @(posedge rst_ni);
    forever begin
      if (served % 40 == 0) out_steady = ($urandom_range(0, 3) == 0);
      hold = out_steady ? 0 : $urandom_range(0, 13);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        seen = out_valid_o;
        @(posedge clk_i);
      end while (!seen);
      served++;
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] gap;
    opcode_e    op;
    logic [7:0] addr;

    in_steady = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte 0 skipped in the first frame, buffer ends, writes past the end
    send_req(OP_WRITE, 8'd0, 8'hFF);
    send_req(OP_WRITE, 8'd1, 8'hA5);
    send_req(OP_WRITE, 8'd191, 8'hFF);
    send_req(OP_WRITE, 8'd192, 8'h5A);
    send_req(OP_WRITE, 8'd255, 8'h00);
    // first eight ticks carry the zeroed shift byte, next eight carry byte 1
    for (int i = 0; i < 16; i++) send_req(OP_TICK, 8'($urandom), 8'($urandom));

    // Random phases, each under its own register setting
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin hi = 8'd255; lo = 8'd0;   gap = 8'd0;   end
        1: begin hi = 8'd0;   lo = 8'd255; gap = 8'd255; end
        default: begin
          hi = 8'($urandom);
          lo = 8'($urandom);
          case ($urandom_range(0, 2))
            0:       gap = 8'd0;
            1:       gap = 8'd255;
            default: gap = 8'($urandom_range(1, 60));
          endcase
        end
      endcase
      program_regs(hi, lo, gap);

      for (int n = 0; n < 325; n++) begin
        if (n % 40 == 0) in_steady = ($urandom_range(0, 4) == 0);
        op = ($urandom_range(0, 9) == 0) ? OP_WRITE : OP_TICK;
        // mostly in-range writes, a few past the end of the buffer
        if (op == OP_WRITE && $urandom_range(0, 7) != 0)
          addr = 8'($urandom_range(0, BufBytes - 1));
        else
          addr = 8'($urandom);
        send_req(op, addr, 8'($urandom));
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #1_500_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
